>>> src/assert_macros.svh
// Assertion macros shared by the quaternion rotate RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QVR_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define QVR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/qvr_pkg.sv
// Package for the quaternion vector rotate block: pipeline control types.
// No dependencies; used by qvr_row and the top level.
package qvr_pkg;

    // Register stages inside one matrix-row unit
    localparam int ROW_STAGES = 3;

    // Control from the top-level valid chain to each row unit
    typedef struct packed {
        logic                  advance;  // whole pipeline moves this cycle
        logic [ROW_STAGES-1:0] load;     // valid word entering each row stage
    } row_ctrl_t;

endpackage

>>> src/qvr_row.sv
// One rotation-matrix row times the vector: multiply, sum with rounding, saturate.
// Depends on qvr_pkg (row_ctrl_t, ROW_STAGES).
module qvr_row #(
    parameter int ENTRY_W    = 33,
    parameter int VEC_WIDTH  = 16,
    parameter int FRAC_SHIFT = 29
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qvr_pkg::row_ctrl_t          ctrl,
    input  logic signed [ENTRY_W-1:0]   coef0,
    input  logic signed [ENTRY_W-1:0]   coef1,
    input  logic signed [ENTRY_W-1:0]   coef2,
    input  logic signed [VEC_WIDTH-1:0] vec0,
    input  logic signed [VEC_WIDTH-1:0] vec1,
    input  logic signed [VEC_WIDTH-1:0] vec2,
    output logic signed [VEC_WIDTH-1:0] rot,
    output logic                        clip
);
    import qvr_pkg::*;

    localparam int PROD_W = ENTRY_W + VEC_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RES_W  = SUM_W - FRAC_SHIFT;

    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W - FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT - 1){1'b0}}};
    localparam logic signed [RES_W-1:0] SAT_MAX =
        {{(RES_W - VEC_WIDTH + 1){1'b0}}, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN =
        {{(RES_W - VEC_WIDTH + 1){1'b1}}, {(VEC_WIDTH - 1){1'b0}}};

    logic signed [PROD_W-1:0]    prod0_reg, prod1_reg, prod2_reg;
    logic signed [PROD_W-1:0]    prod0_next, prod1_next, prod2_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic signed [RES_W-1:0]     shifted;
    logic signed [VEC_WIDTH-1:0] rot_reg, rot_next;
    logic                        clip_reg, clip_next;

    // Stage A: three products of matrix entry and vector component
    assign prod0_next = PROD_W'(coef0) * PROD_W'(vec0);
    assign prod1_next = PROD_W'(coef1) * PROD_W'(vec1);
    assign prod2_next = PROD_W'(coef2) * PROD_W'(vec2);

    // Stage B: dot product plus rounding half
    assign sum_next = SUM_W'(prod0_reg) + SUM_W'(prod1_reg) + SUM_W'(prod2_reg) + HALF;

    // Stage C: drop fraction bits, clamp to output range
    assign shifted = RES_W'(sum_reg >>> FRAC_SHIFT);

    always_comb
    begin
        priority if (shifted > SAT_MAX)
        begin
            rot_next  = SAT_MAX[VEC_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else if (shifted < SAT_MIN)
        begin
            rot_next  = SAT_MIN[VEC_WIDTH-1:0];
            clip_next = 1'b1;
        end
        else
        begin
            rot_next  = shifted[VEC_WIDTH-1:0];
            clip_next = 1'b0;
        end
    end

    // Data registers load only when a valid word enters the stage
    always_ff @(posedge clk)
    begin
        if (ctrl.advance && ctrl.load[0])
        begin
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            prod2_reg <= prod2_next;
        end
        if (ctrl.advance && ctrl.load[1])
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.advance && ctrl.load[ROW_STAGES-1])
        begin
            rot_reg <= rot_next;
        end
    end

    // Clip flag is reset so the output flag is clean after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (ctrl.advance && ctrl.load[ROW_STAGES-1])
        begin
            clip_reg <= clip_next;
        end
    end

    assign rot  = rot_reg;
    assign clip = clip_reg;

endmodule

>>> src/quaternion_vector_rotate_unit.sv
// Top level of the quaternion vector rotate block: quaternion products,
// matrix entries, three row units and the valid/stall pipeline control.
// Depends on qvr_pkg, qvr_row and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_stall   | quat_x/y/z/w, vec_x/y/z
//  out     | output    | out_valid / out_stall | rot_x/y/z, clipped
//
// One word per cycle in and out while no output word is stalled; two stages of
// quaternion products and matrix entries, then three stages in each row unit.
// Reset clears the valid chain and the clip flags; data registers are not reset.
// A stall on a waiting output word freezes every stage; in_stall follows within
// the cycle, so no word is dropped or repeated.
module quaternion_vector_rotate_unit #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [VEC_WIDTH-1:0]  vec_x,
    input  logic signed [VEC_WIDTH-1:0]  vec_y,
    input  logic signed [VEC_WIDTH-1:0]  vec_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VEC_WIDTH-1:0]  rot_x,
    output logic signed [VEC_WIDTH-1:0]  rot_y,
    output logic signed [VEC_WIDTH-1:0]  rot_z,
    output logic                         clipped
);
    import qvr_pkg::*;

`include "assert_macros.svh"

    localparam int PROD_W     = 2 * QUAT_WIDTH;
    localparam int FRAC_SHIFT = 2 * QUAT_WIDTH - 3;
    localparam int ENTRY_FULL = 2 * QUAT_WIDTH + 1;
    // Matrix entries wrap to 64 bits at the widest setting
    localparam int ENTRY_W    = (ENTRY_FULL > 64) ? 64 : ENTRY_FULL;
    localparam int STAGES     = 2 + ROW_STAGES;

    localparam logic signed [ENTRY_FULL-1:0] ONE_FIX =
        {{(ENTRY_FULL - FRAC_SHIFT - 1){1'b0}}, 1'b1, {FRAC_SHIFT{1'b0}}};
    localparam logic signed [VEC_WIDTH-1:0] OUT_MAX = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] OUT_MIN = {1'b1, {(VEC_WIDTH - 1){1'b0}}};

    logic              advance;
    logic [STAGES-1:0] valid_reg, valid_next;
    row_ctrl_t         row_ctrl;

    // Stage 1 registers: quaternion products and vector
    logic signed [PROD_W-1:0]    p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [PROD_W-1:0]    p_xy_reg, p_xz_reg, p_yz_reg;
    logic signed [PROD_W-1:0]    p_wx_reg, p_wy_reg, p_wz_reg;
    logic signed [VEC_WIDTH-1:0] v1_x_reg, v1_y_reg, v1_z_reg;

    // Stage 2 registers: matrix entries and vector
    logic signed [ENTRY_W-1:0]    m_reg  [3][3];
    logic signed [ENTRY_W-1:0]    m_next [3][3];
    logic signed [ENTRY_FULL-1:0] e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [VEC_WIDTH-1:0]  v2_x_reg, v2_y_reg, v2_z_reg;

    logic signed [VEC_WIDTH-1:0] row_rot  [3];
    logic [2:0]                  row_clip;

    // Global stall: everything holds while the output word waits
    assign advance  = !(valid_reg[STAGES-1] && out_stall);
    assign in_stall = !advance;

    assign valid_next = {valid_reg[STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: the nine quaternion products
    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            p_xx_reg <= PROD_W'(quat_x) * PROD_W'(quat_x);
            p_yy_reg <= PROD_W'(quat_y) * PROD_W'(quat_y);
            p_zz_reg <= PROD_W'(quat_z) * PROD_W'(quat_z);
            p_xy_reg <= PROD_W'(quat_x) * PROD_W'(quat_y);
            p_xz_reg <= PROD_W'(quat_x) * PROD_W'(quat_z);
            p_yz_reg <= PROD_W'(quat_y) * PROD_W'(quat_z);
            p_wx_reg <= PROD_W'(quat_w) * PROD_W'(quat_x);
            p_wy_reg <= PROD_W'(quat_w) * PROD_W'(quat_y);
            p_wz_reg <= PROD_W'(quat_w) * PROD_W'(quat_z);
            v1_x_reg <= vec_x;
            v1_y_reg <= vec_y;
            v1_z_reg <= vec_z;
        end
    end

    // Stage 2: matrix entries at half scale (products carry the factor two)
    assign e_xx = ENTRY_FULL'(p_xx_reg);
    assign e_yy = ENTRY_FULL'(p_yy_reg);
    assign e_zz = ENTRY_FULL'(p_zz_reg);
    assign e_xy = ENTRY_FULL'(p_xy_reg);
    assign e_xz = ENTRY_FULL'(p_xz_reg);
    assign e_yz = ENTRY_FULL'(p_yz_reg);
    assign e_wx = ENTRY_FULL'(p_wx_reg);
    assign e_wy = ENTRY_FULL'(p_wy_reg);
    assign e_wz = ENTRY_FULL'(p_wz_reg);

    always_comb
    begin
        m_next[0][0] = ENTRY_W'(ONE_FIX - (e_yy + e_zz));
        m_next[0][1] = ENTRY_W'(e_xy - e_wz);
        m_next[0][2] = ENTRY_W'(e_xz + e_wy);
        m_next[1][0] = ENTRY_W'(e_xy + e_wz);
        m_next[1][1] = ENTRY_W'(ONE_FIX - (e_xx + e_zz));
        m_next[1][2] = ENTRY_W'(e_yz - e_wx);
        m_next[2][0] = ENTRY_W'(e_xz - e_wy);
        m_next[2][1] = ENTRY_W'(e_yz + e_wx);
        m_next[2][2] = ENTRY_W'(ONE_FIX - (e_xx + e_yy));
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_reg[0])
        begin
            m_reg    <= m_next;
            v2_x_reg <= v1_x_reg;
            v2_y_reg <= v1_y_reg;
            v2_z_reg <= v1_z_reg;
        end
    end

    // Stages 3 to 5: one unit per matrix row
    assign row_ctrl.advance = advance;
    assign row_ctrl.load    = valid_reg[STAGES-2:1];

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        qvr_row #(
            .ENTRY_W    (ENTRY_W),
            .VEC_WIDTH  (VEC_WIDTH),
            .FRAC_SHIFT (FRAC_SHIFT)
        ) u_row (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (row_ctrl),
            .coef0 (m_reg[r][0]),
            .coef1 (m_reg[r][1]),
            .coef2 (m_reg[r][2]),
            .vec0  (v2_x_reg),
            .vec1  (v2_y_reg),
            .vec2  (v2_z_reg),
            .rot   (row_rot[r]),
            .clip  (row_clip[r])
        );
    end

    // Output word
    assign out_valid = valid_reg[STAGES-1];
    assign rot_x     = row_rot[0];
    assign rot_y     = row_rot[1];
    assign rot_z     = row_rot[2];
    assign clipped   = |row_clip;

    // Pipeline control checks
    `QVR_ASSERT_NEXT(a_hold_valids, !advance, $stable(valid_reg),
        "valid chain moved during stall")
    `QVR_ASSERT_IMPL(a_stall_needs_word, in_stall, out_valid,
        "input stalled with no output word waiting")
    `QVR_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_reg[0],
        "accepted word did not enter the first stage")
    `QVR_ASSERT_IMPL(a_clip_at_limit, out_valid && clipped,
        rot_x == OUT_MAX || rot_x == OUT_MIN || rot_y == OUT_MAX ||
        rot_y == OUT_MIN || rot_z == OUT_MAX || rot_z == OUT_MIN,
        "clipped set with no component at a limit")

endmodule

>>> bench/qvr_checker.sv
// Checker for the quaternion vector rotate unit: watches both channels, predicts
// each rotated word from the input word and compares it field by field.
// Standalone module, no package needed; instantiated by quaternion_vector_rotate_unit_tb.
module qvr_checker #(
    parameter int QUAT_WIDTH = 16,
    parameter int VEC_WIDTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [VEC_WIDTH-1:0]  vec_x,
    input  logic signed [VEC_WIDTH-1:0]  vec_y,
    input  logic signed [VEC_WIDTH-1:0]  vec_z,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [VEC_WIDTH-1:0]  rot_x,
    input  logic signed [VEC_WIDTH-1:0]  rot_y,
    input  logic signed [VEC_WIDTH-1:0]  rot_z,
    input  logic                         clipped,
    output int                           mismatches,
    output int                           pending,
    output int                           checked,
    output int                           clip_seen
);

    // matrix entries carry 2*QUAT_WIDTH-3 fraction bits at half scale
    localparam int     FRAC_BITS = 2 * QUAT_WIDTH - 3;
    localparam longint VEC_MAX   = (longint'(1) <<< (VEC_WIDTH - 1)) - 1;
    localparam longint VEC_MIN   = -(longint'(1) <<< (VEC_WIDTH - 1));

    typedef struct {
        logic signed [VEC_WIDTH-1:0] x;
        logic signed [VEC_WIDTH-1:0] y;
        logic signed [VEC_WIDTH-1:0] z;
        logic                        clip;
    } rotated_t;

    rotated_t rotated_q[$];
    int       error_count = 0;

    // Rotation matrix from the doubled quaternion products, times the vector,
    // rounded half up and saturated per component.
    function automatic rotated_t rotate_vector(
        input logic signed [QUAT_WIDTH-1:0] qx, qy, qz, qw,
        input logic signed [VEC_WIDTH-1:0]  vx, vy, vz
    );
        longint   x, y, z, w;
        longint   pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
        longint   one, acc, r;
        longint   m[9];
        longint   v[3];
        logic signed [VEC_WIDTH-1:0] lane[3];
        rotated_t res;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        pxx = x * x;
        pyy = y * y;
        pzz = z * z;
        pxy = x * y;
        pxz = x * z;
        pyz = y * z;
        pwx = w * x;
        pwy = w * y;
        pwz = w * z;
        one = longint'(1) <<< FRAC_BITS;
        m[0] = one - (pyy + pzz);
        m[1] = pxy - pwz;
        m[2] = pxz + pwy;
        m[3] = pxy + pwz;
        m[4] = one - (pxx + pzz);
        m[5] = pyz - pwx;
        m[6] = pxz - pwy;
        m[7] = pyz + pwx;
        m[8] = one - (pxx + pyy);
        res.clip = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[3*i] * v[0] + m[3*i+1] * v[1] + m[3*i+2] * v[2];
            r = (acc + (one >>> 1)) >>> FRAC_BITS;
            if (r > VEC_MAX)
            begin
                r = VEC_MAX;
                res.clip = 1'b1;
            end
            else if (r < VEC_MIN)
            begin
                r = VEC_MIN;
                res.clip = 1'b1;
            end
            lane[i] = r[VEC_WIDTH-1:0];
        end
        res.x = lane[0];
        res.y = lane[1];
        res.z = lane[2];
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [VEC_WIDTH-1:0] want,
                               input logic signed [VEC_WIDTH-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sample both channels at the edge; outputs are handed over with NBAs
    always @(posedge clk)
    begin
        rotated_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                rotated_q.push_back(rotate_vector(quat_x, quat_y, quat_z, quat_w,
                                                  vec_x, vec_y, vec_z));
            if (out_valid && !out_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result word with none expected, got %0d %0d %0d clip %0b",
                             $time, rot_x, rot_y, rot_z, clipped);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("rot_x", want.x, rot_x);
                    check_field("rot_y", want.y, rot_y);
                    check_field("rot_z", want.z, rot_z);
                    check_field("clipped", VEC_WIDTH'(want.clip), VEC_WIDTH'(clipped));
                    checked <= checked + 1;
                    if (want.clip)
                        clip_seen <= clip_seen + 1;
                end
            end
        end
        mismatches <= error_count;
        pending    <= rotated_q.size();
    end

endmodule

>>> bench/quaternion_vector_rotate_unit_tb.sv
// Testbench top for quaternion_vector_rotate_unit: clock, reset, directed and
// random input words, random output stalls and the verdict. Depends on qvr_checker.
module quaternion_vector_rotate_unit_tb;

    localparam int QW           = 16;
    localparam int VW           = 16;
    localparam int RANDOM_WORDS = 450;
    localparam int CALM_WORDS   = 60;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [VW-1:0] vec_x, vec_y, vec_z;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [VW-1:0] rot_x, rot_y, rot_z;
    logic                 clipped;

    int mismatches, pending, checked, clip_seen;
    int words_sent = 0;
    int cycles     = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    quaternion_vector_rotate_unit #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped)
    );

    qvr_checker #(.QUAT_WIDTH(QW), .VEC_WIDTH(VW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped),
        .mismatches(mismatches), .pending(pending), .checked(checked),
        .clip_seen(clip_seen)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, none once the run turns calm
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // One input word: optional idle burst, then hold until accepted
    task automatic send_word(input logic [QW-1:0] qx, qy, qz, qw,
                             input logic [VW-1:0] vx, vy, vz);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x   <= qx;
        quat_y   <= qy;
        quat_z   <= qz;
        quat_w   <= qw;
        vec_x    <= vx;
        vec_y    <= vy;
        vec_z    <= vz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Boundary values mixed with plain random ones
    function automatic logic [15:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Quaternion component with magnitude at most one half, so |q| <= 1
    function automatic logic [15:0] half_value();
        return 16'($urandom_range(0, 32767) - 16384);
    endfunction

    function automatic logic [15:0] any_value();
        return 16'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int kind;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        quat_x   <= '0;
        quat_y   <= '0;
        quat_z   <= '0;
        quat_w   <= '0;
        vec_x    <= '0;
        vec_y    <= '0;
        vec_z    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero quaternion is identity at half scale
        send_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h0000);
        // near-identity with extreme vectors
        send_word(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_word(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        // 180 degrees about each axis
        send_word(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'd1000, 16'd2000, 16'd3000);
        send_word(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'd1000, 16'd2000, 16'd3000);
        send_word(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'd1000, 16'd2000, 16'd3000);
        // 90 degrees about x and about z
        send_word(16'd23170, 16'h0000, 16'h0000, 16'd23170, 16'd12345, 16'hC000, 16'd777);
        send_word(16'h0000, 16'h0000, 16'd23170, 16'd23170, 16'h8000, 16'h7FFF, 16'h0001);
        // rounding ties: half-scale diagonal on x and z, odd vector components
        send_word(16'h0000, 16'd16384, 16'h0000, 16'h0000, 16'd1, 16'hFFFF, 16'd3);
        send_word(16'h0000, 16'd16384, 16'h0000, 16'h0000, 16'hFFFF, 16'd5, 16'hFFFD);
        // most negative quaternion with equal-component vectors, then overflow both ways
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        // unnormalized, small quaternion
        send_word(16'd1000, 16'hF830, 16'd300, 16'd5, 16'd20000, 16'hB1E0, 16'd9999);
        send_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Let the pipeline drain before the random part
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random words
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: send_word(any_value(), any_value(), any_value(), any_value(),
                                any_value(), any_value(), any_value());
                2, 3, 4, 5: send_word(half_value(), half_value(), half_value(), half_value(),
                                      any_value(), any_value(), any_value());
                6, 7: send_word(half_value(), half_value(), half_value(), half_value(),
                                16'($urandom_range(0, 2047) - 1024),
                                16'($urandom_range(0, 2047) - 1024),
                                16'($urandom_range(0, 2047) - 1024));
                8: send_word(edge_value(), edge_value(), edge_value(), edge_value(),
                             edge_value(), edge_value(), edge_value());
                default: send_word(any_value(), any_value(), any_value(), any_value(),
                                   16'($urandom_range(0, 255) - 128),
                                   16'($urandom_range(0, 255) - 128),
                                   16'($urandom_range(0, 255) - 128));
            endcase
        end
        in_valid <= 1'b0;

        // Drain, then wait out the pipeline before the verdict
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        $display("Sent %0d words (directed edge cases, ties, overflow, random mix);", words_sent);
        $display("checked %0d rotated words, %0d of them saturated.", checked, clip_seen);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> quaternion_vector_rotate_unit.f
+incdir+src
src/qvr_pkg.sv
src/qvr_row.sv
src/quaternion_vector_rotate_unit.sv
bench/qvr_checker.sv
bench/quaternion_vector_rotate_unit_tb.sv
